// ===== rtl/core/scta_pkg.sv =====
// ----------------------------------------------------------------------------
// scta_pkg
// shared types, constants and the set 1 key table for the scancode typist
// ----------------------------------------------------------------------------
package scta_pkg;

    // scancode byte fields
    localparam int CODE_W = 8;
    localparam int KEY_W  = 7;
    localparam int CHAR_W = 8;
    localparam int COL_W  = 8;
    localparam int SCOL_W = 7;
    localparam int ROW_W  = 5;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_START_COLUMN = 1'd0;
    localparam t_cfg_idx CFG_CURSOR_ROW   = 1'd1;

    // reset values of the configuration registers
    localparam logic [SCOL_W-1:0] START_COLUMN_RST = 7'd1;
    localparam logic [ROW_W-1:0]  CURSOR_ROW_RST   = 5'd3;

    // event kinds
    localparam logic EVT_PRINT = 1'b0;
    localparam logic EVT_ERASE = 1'b1;

    // special scancodes and character constants
    localparam logic [KEY_W-1:0]  KEY_LSHIFT  = 7'h2a;
    localparam logic [CODE_W-1:0] CODE_LSHIFT = 8'h2a;
    localparam logic [CODE_W-1:0] CODE_BKSP   = 8'h0e;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;
    localparam logic [CHAR_W-1:0] ERASE_CHAR  = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NONE   = 8'h00;

    // one decoded event
    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
    } t_event;

    // result of decoding one scancode against the current state
    typedef struct packed {
        logic             has_event;
        t_event           evt;
        logic             shift_next;
        logic [COL_W-1:0] column_next;
    } t_decode;

    // lower-case character of a make code, CHAR_NONE when unmapped
    function automatic logic [CHAR_W-1:0] key_lookup(input logic [KEY_W-1:0] key);
        logic [CHAR_W-1:0] ch;
        case (key)
            7'h02:   ch = "1";
            7'h03:   ch = "2";
            7'h04:   ch = "3";
            7'h05:   ch = "4";
            7'h06:   ch = "5";
            7'h07:   ch = "6";
            7'h08:   ch = "7";
            7'h09:   ch = "8";
            7'h0a:   ch = "9";
            7'h0b:   ch = "0";
            7'h0c:   ch = "-";
            7'h0d:   ch = "=";
            7'h0f:   ch = 8'h09;
            7'h10:   ch = "q";
            7'h11:   ch = "w";
            7'h12:   ch = "e";
            7'h13:   ch = "r";
            7'h14:   ch = "t";
            7'h15:   ch = "y";
            7'h16:   ch = "u";
            7'h17:   ch = "i";
            7'h18:   ch = "o";
            7'h19:   ch = "p";
            7'h1e:   ch = "a";
            7'h1f:   ch = "s";
            7'h20:   ch = "d";
            7'h21:   ch = "f";
            7'h22:   ch = "g";
            7'h23:   ch = "h";
            7'h24:   ch = "j";
            7'h25:   ch = "k";
            7'h26:   ch = "l";
            7'h2c:   ch = "z";
            7'h2d:   ch = "x";
            7'h2e:   ch = "c";
            7'h2f:   ch = "v";
            7'h30:   ch = "b";
            7'h31:   ch = "n";
            7'h32:   ch = "m";
            7'h39:   ch = " ";
            default: ch = CHAR_NONE;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/core/scta_if.sv =====
// ----------------------------------------------------------------------------
// scta channel interfaces
// valid/ready channels for scancodes, typing events and configuration
// ----------------------------------------------------------------------------
interface scta_code_if
    import scta_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] scancode;

    modport source (output valid, output scancode, input ready);
    modport sink   (input valid, input scancode, output ready);
endinterface

interface scta_event_if
    import scta_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              event_kind;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  row_out;

    modport source (output valid, output event_kind, output char_code,
                    output cursor_column, output row_out, input ready);
    modport sink   (input valid, input event_kind, input char_code,
                    input cursor_column, input row_out, output ready);
endinterface

interface scta_cfg_if
    import scta_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/scta_decode.sv =====
// ----------------------------------------------------------------------------
// scta_decode
// combinational decode of one scancode against shift flag and column
// ----------------------------------------------------------------------------
module scta_decode
    import scta_pkg::*;
(
    input  logic [CODE_W-1:0] i_code,
    input  logic              i_shift,
    input  logic [COL_W-1:0]  i_column,
    input  logic [ROW_W-1:0]  i_row,
    output t_decode           o_res
);

    logic [CHAR_W-1:0] lower_char;

    assign lower_char = key_lookup(i_code[KEY_W-1:0]);

    always_comb begin
        o_res               = '0;
        o_res.shift_next    = i_shift;
        o_res.column_next   = i_column;
        o_res.evt.row       = i_row;
        o_res.evt.kind      = EVT_PRINT;
        o_res.evt.char_code = lower_char;
        o_res.evt.column    = i_column;

        if (i_code[CODE_W-1]) begin
            // release: only left shift matters
            if (i_code[KEY_W-1:0] == KEY_LSHIFT) begin
                o_res.shift_next = 1'b0;
            end
        end else if (i_code == CODE_LSHIFT) begin
            o_res.shift_next = 1'b1;
        end else if (i_code == CODE_BKSP) begin
            if (i_column != '0) begin
                o_res.has_event     = 1'b1;
                o_res.column_next   = i_column - COL_W'(1);
                o_res.evt.kind      = EVT_ERASE;
                o_res.evt.char_code = ERASE_CHAR;
                o_res.evt.column    = i_column - COL_W'(1);
            end
        end else if (lower_char != CHAR_NONE) begin
            o_res.has_event   = 1'b1;
            o_res.column_next = i_column + COL_W'(1);
            if (i_shift) begin
                o_res.evt.char_code = lower_char - CASE_OFFSET;
                o_res.shift_next    = 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/scta_out_reg.sv =====
// ----------------------------------------------------------------------------
// scta_out_reg
// result register driving the event channel
// ----------------------------------------------------------------------------
module scta_out_reg
    import scta_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  t_event       i_evt,
    output logic         o_can_load,
    scta_event_if.source o_event
);

    logic   r_valid;
    t_event r_evt;

    // free when empty or when the held event leaves this cycle
    assign o_can_load = !r_valid || o_event.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_evt <= i_evt;
        end
    end

    assign o_event.valid         = r_valid;
    assign o_event.event_kind    = r_evt.kind;
    assign o_event.char_code     = r_evt.char_code;
    assign o_event.cursor_column = r_evt.column;
    assign o_event.row_out       = r_evt.row;

endmodule

// ===== rtl/core/scancode_to_ascii_typist.sv =====
// ----------------------------------------------------------------------------
// scancode_to_ascii_typist
// turns set 1 keyboard scancodes into print and erase events on one text row
// ----------------------------------------------------------------------------
// usage
//   i_scan   : scancode bytes in, one per transaction
//   o_event  : print / erase events out, at most one per scancode
//   i_cfg    : register writes, index 0 start column (also reloads the
//              cursor column), index 1 cursor row; always ready, to be used
//              only while no scancode is in flight
// timing
//   a scancode goes into an input register, is decoded from there against
//   the shift flag and column, and its event lands in the output register
//   one scancode per cycle sustained while o_event.ready stays high, set by
//   the single decode stage
// reset
//   synchronous, active low; start column 1, row 3, shift clear, column 1
// stalls
//   with o_event.ready low the held event stays put and the input register
//   still fills; i_scan.ready drops only once both stages are occupied
// ----------------------------------------------------------------------------
module scancode_to_ascii_typist
    import scta_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    scta_code_if.sink   i_scan,
    scta_event_if.source o_event,
    scta_cfg_if.sink    i_cfg
);

    // input register
    logic              r_in_valid;
    logic [CODE_W-1:0] r_in_code;

    // typing state
    logic              r_shift;
    logic [COL_W-1:0]  r_column;

    // configuration
    logic [ROW_W-1:0]  r_row;

    t_decode dec;
    logic    out_can_load;
    logic    advance;
    logic    in_take;
    logic    cfg_wr;

    // the held scancode is consumed when the result register can take it
    assign advance = r_in_valid && out_can_load;
    assign i_scan.ready = !r_in_valid || advance;
    assign in_take = i_scan.valid && i_scan.ready;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_scan.ready) begin
            r_in_valid <= i_scan.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_code <= i_scan.scancode;
        end
    end

    // shift flag and cursor column; a start column write reloads the column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= 1'b0;
            r_column <= COL_W'(START_COLUMN_RST);
        end else if (cfg_wr && i_cfg.index == CFG_START_COLUMN) begin
            r_column <= COL_W'(i_cfg.data[SCOL_W-1:0]);
        end else if (advance) begin
            r_shift  <= dec.shift_next;
            r_column <= dec.column_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= CURSOR_ROW_RST;
        end else if (cfg_wr && i_cfg.index == CFG_CURSOR_ROW) begin
            r_row <= i_cfg.data[ROW_W-1:0];
        end
    end

    scta_decode u_decode (
        .i_code   (r_in_code),
        .i_shift  (r_shift),
        .i_column (r_column),
        .i_row    (r_row),
        .o_res    (dec)
    );

    scta_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance && dec.has_event),
        .i_evt      (dec.evt),
        .o_can_load (out_can_load),
        .o_event    (o_event)
    );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the scancode typist: a queue-fed driver sends
// scancodes and register writes, a monitor predicts every print and erase
// event from its own copy of shift flag and column and checks the event port
// ----------------------------------------------------------------------------
module testbench;
    import scta_pkg::*;

    // timing of the run
    localparam int CLK_HALF     = 10;
    localparam int RST_CYCLES   = 5;
    localparam int SETTLE_CYC   = 6;    // two-stage pipe plus margin
    localparam int END_CYC      = 8;
    localparam int WD_LIMIT     = 500;
    localparam int TAIL_ITEMS   = 150;  // last stretch runs without idling
    localparam int MAX_ERR_SHOW = 100;

    // scancodes with a special meaning for the typist
    localparam logic [CODE_W-1:0] RELEASE_MASK = 8'h80;
    localparam logic [CODE_W-1:0] SHIFT_BREAK  = CODE_LSHIFT | RELEASE_MASK;
    localparam logic [CODE_W-1:0] SC_SPACE     = 8'h39;
    localparam logic [CODE_W-1:0] SC_TAB       = 8'h0f;
    localparam logic [CODE_W-1:0] SC_UNMAPPED  = 8'h01;
    localparam logic [CODE_W-1:0] SC_KEY_A     = 8'h1e;
    localparam logic [CODE_W-1:0] SC_KEY_A_UP  = SC_KEY_A | RELEASE_MASK;

    typedef enum logic [1:0] {ITEM_SCAN, ITEM_CFG, ITEM_SETTLE} t_item_kind;

    typedef struct {
        t_item_kind            kind;
        logic [CODE_W-1:0]     code;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
    } t_stim;

    logic i_clk;
    logic i_rst_n;

    scta_code_if  scan_if ();
    scta_event_if evt_if ();
    scta_cfg_if   cfg_if ();

    scancode_to_ascii_typist i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scan  (scan_if),
        .o_event (evt_if),
        .i_cfg   (cfg_if)
    );

    // stimulus still to be sent and events still to arrive
    t_stim  stim_q[$];
    t_event pending_events[$];

    // own set 1 key table and the list of printable make codes
    logic [CHAR_W-1:0] keymap [128];
    logic [KEY_W-1:0]  mapped_keys[$];

    // predicted typist state
    logic              shift_q;
    logic [COL_W-1:0]  col_q;
    logic [SCOL_W-1:0] start_q;
    logic [ROW_W-1:0]  row_q;

    // bookkeeping shared between driver, monitor and watchdog
    logic stim_done   = 1'b0;
    logic nothing_due = 1'b1;
    logic idle_on     = 1'b0;
    int   quiet_cnt   = 0;
    int   wd_cnt      = 0;
    int   src_gap     = 0;
    int   snk_gap     = 0;
    int   cyc_cnt     = 0;
    int   err_cnt     = 0;
    int   scan_cnt    = 0;
    int   print_cnt   = 0;
    int   erase_cnt   = 0;
    int   shifted_cnt = 0;
    int   cfg_cnt     = 0;
    int   wrap_cnt    = 0;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------

    // one line per mismatch, the count goes on past the print cap
    task automatic note_mismatch(input string what, input int got, input int want);
        err_cnt++;
        if (err_cnt <= MAX_ERR_SHOW) begin
            $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        end
    endtask

    // key rows laid out by scancode position, plus tab and space
    task automatic load_keymap();
        string rows [4];
        int    first [4];
        string s;
        rows  = '{"1234567890-=", "qwertyuiop", "asdfghjkl", "zxcvbnm"};
        first = '{2, 16, 30, 44};
        for (int k = 0; k < 128; k++) keymap[k] = CHAR_NONE;
        for (int r = 0; r < 4; r++) begin
            s = rows[r];
            for (int i = 0; i < s.len(); i++) keymap[first[r] + i] = s[i];
        end
        keymap[SC_TAB[KEY_W-1:0]]   = 8'h09;
        keymap[SC_SPACE[KEY_W-1:0]] = " ";
        for (int k = 0; k < 128; k++) begin
            if (keymap[k] != CHAR_NONE) mapped_keys.push_back(k[KEY_W-1:0]);
        end
    endtask

    // typist behaviour for one accepted scancode
    task automatic advance_typist(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        t_event            ev;
        ev.row = row_q;
        if ((code & RELEASE_MASK) != '0) begin
            // only the shift release matters among break codes
            if (code[KEY_W-1:0] == KEY_LSHIFT) shift_q = 1'b0;
        end else if (code == CODE_LSHIFT) begin
            shift_q = 1'b1;
        end else if (code == CODE_BKSP) begin
            // backspace at the left edge is dropped silently
            if (col_q != '0) begin
                col_q        = col_q - 1'b1;
                ev.kind      = EVT_ERASE;
                ev.char_code = ERASE_CHAR;
                ev.column    = col_q;
                pending_events.push_back(ev);
                erase_cnt++;
            end
        end else begin
            ch = keymap[code[KEY_W-1:0]];
            if (ch != CHAR_NONE) begin
                // shift is one-shot and offsets non-letters too, tab wraps
                if (shift_q) begin
                    ch      = ch - CASE_OFFSET;
                    shift_q = 1'b0;
                    shifted_cnt++;
                end
                ev.kind      = EVT_PRINT;
                ev.char_code = ch;
                ev.column    = col_q;
                pending_events.push_back(ev);
                if (col_q == '1) wrap_cnt++;
                col_q = col_q + 1'b1;
                print_cnt++;
            end
        end
    endtask

    // random scancode, typing_pct percent printable make codes
    function automatic logic [CODE_W-1:0] pick_scancode(input int typing_pct);
        int                roll;
        logic [CODE_W-1:0] c;
        roll = $urandom_range(0, 99);
        if (roll < typing_pct) begin
            c = {1'b0, mapped_keys[$urandom_range(0, mapped_keys.size() - 1)]};
        end else begin
            case ($urandom_range(0, 9))
                0, 1:    c = CODE_LSHIFT;
                2:       c = SHIFT_BREAK;
                3, 4:    c = CODE_BKSP;
                5, 6: begin
                    c = {1'b1, mapped_keys[$urandom_range(0, mapped_keys.size() - 1)]};
                end
                default: c = CODE_W'($urandom_range(0, 255));
            endcase
        end
        return c;
    endfunction

    task automatic queue_code(input logic [CODE_W-1:0] code);
        t_stim it;
        it.kind = ITEM_SCAN;
        it.code = code;
        it.idx  = CFG_START_COLUMN;
        it.data = '0;
        stim_q.push_back(it);
    endtask

    task automatic queue_settle();
        t_stim it;
        it.kind = ITEM_SETTLE;
        it.code = '0;
        it.idx  = CFG_START_COLUMN;
        it.data = '0;
        stim_q.push_back(it);
    endtask

    // register writes only once the pipe has drained
    task automatic queue_settings(input int start_col, input int row);
        t_stim it;
        queue_settle();
        it.kind = ITEM_CFG;
        it.code = '0;
        it.idx  = CFG_START_COLUMN;
        it.data = CFG_DATA_W'(start_col);
        stim_q.push_back(it);
        it.idx  = CFG_CURSOR_ROW;
        it.data = CFG_DATA_W'(row);
        stim_q.push_back(it);
    endtask

    // n random scancodes, with a full drain before item settle_at (-1 for none)
    task automatic queue_phase(input int n, input int typing_pct, input int settle_at);
        for (int i = 0; i < n; i++) begin
            if (i == settle_at) queue_settle();
            queue_code(pick_scancode(typing_pct));
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: scancode and register write channels, fed from stim_q
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : stim_driver
        logic                  nxt_scan_vld;
        logic                  nxt_cfg_vld;
        logic [CODE_W-1:0]     nxt_code;
        t_cfg_idx              nxt_idx;
        logic [CFG_DATA_W-1:0] nxt_data;
        nxt_scan_vld = scan_if.valid;
        nxt_cfg_vld  = cfg_if.valid;
        nxt_code     = scan_if.scancode;
        nxt_idx      = cfg_if.index;
        nxt_data     = cfg_if.data;
        if (!i_rst_n) begin
            nxt_scan_vld = 1'b0;
            nxt_cfg_vld  = 1'b0;
        end else begin
            cyc_cnt++;
            // a transaction still waiting for ready holds its payload
            if (!((scan_if.valid && !scan_if.ready) || (cfg_if.valid && !cfg_if.ready))) begin
                nxt_scan_vld = 1'b0;
                nxt_cfg_vld  = 1'b0;
                if (stim_q.size() != 0) begin
                    case (stim_q[0].kind)
                        ITEM_SCAN: begin
                            if (src_gap > 0) begin
                                src_gap--;
                            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                                // start a burst of idle cycles, this one included, its rest drawn into src_gap
                                src_gap = $urandom_range(0, 2);
                            end else begin
                                nxt_scan_vld = 1'b1;
                                nxt_code     = stim_q[0].code;
                                void'(stim_q.pop_front());
                            end
                        end
                        ITEM_CFG: begin
                            nxt_cfg_vld = 1'b1;
                            nxt_idx     = stim_q[0].idx;
                            nxt_data    = stim_q[0].data;
                            void'(stim_q.pop_front());
                        end
                        ITEM_SETTLE: begin
                            // hold off until every event is in and the pipe is quiet
                            if (nothing_due && quiet_cnt >= SETTLE_CYC) begin
                                void'(stim_q.pop_front());
                            end
                        end
                        default: begin
                            void'(stim_q.pop_front());
                        end
                    endcase
                end
            end
        end
        scan_if.valid    <= nxt_scan_vld;
        scan_if.scancode <= nxt_code;
        cfg_if.valid     <= nxt_cfg_vld;
        cfg_if.index     <= nxt_idx;
        cfg_if.data      <= nxt_data;
        stim_done        <= i_rst_n && stim_q.size() == 0 && !nxt_scan_vld && !nxt_cfg_vld;
        // idle windows recur with cyc_cnt, none in the tail
        idle_on          <= stim_q.size() > TAIL_ITEMS && (cyc_cnt % 300) < 200;
    end

    // ------------------------------------------------------------------------
    // monitor: prediction on accepted transactions, checking of events,
    // back-pressure on the event port
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : event_monitor
        t_event want;
        logic   any_xfer;
        logic   nxt_ready;
        if (!i_rst_n) begin
            start_q     = START_COLUMN_RST;
            row_q       = CURSOR_ROW_RST;
            shift_q     = 1'b0;
            col_q       = COL_W'(START_COLUMN_RST);
            snk_gap     = 0;
            nxt_ready   = 1'b1;
            any_xfer    = 1'b0;
            quiet_cnt   <= 0;
        end else begin
            any_xfer = 1'b0;
            // register write: start column also reloads the cursor
            if (cfg_if.valid && cfg_if.ready) begin
                any_xfer = 1'b1;
                cfg_cnt++;
                if (cfg_if.index == CFG_START_COLUMN) begin
                    start_q = cfg_if.data[SCOL_W-1:0];
                    col_q   = COL_W'(start_q);
                end else begin
                    row_q = cfg_if.data[ROW_W-1:0];
                end
            end
            if (scan_if.valid && scan_if.ready) begin
                any_xfer = 1'b1;
                scan_cnt++;
                advance_typist(scan_if.scancode);
            end
            if (evt_if.valid && evt_if.ready) begin
                any_xfer = 1'b1;
                if (pending_events.size() == 0) begin
                    note_mismatch("event with none expected, column", evt_if.cursor_column, 0);
                end else begin
                    want = pending_events.pop_front();
                    if (evt_if.event_kind != want.kind)
                        note_mismatch("event_kind", evt_if.event_kind, want.kind);
                    if (evt_if.char_code != want.char_code)
                        note_mismatch("char_code", evt_if.char_code, want.char_code);
                    if (evt_if.cursor_column != want.column)
                        note_mismatch("cursor_column", evt_if.cursor_column, want.column);
                    if (evt_if.row_out != want.row)
                        note_mismatch("row_out", evt_if.row_out, want.row);
                end
            end
            // receiver stalls in random bursts while idling is on
            if (snk_gap > 0) begin
                snk_gap--;
                nxt_ready = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                snk_gap   = $urandom_range(0, 2);
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
            end
            // quiet time restarts on scancode or event traffic
            if ((scan_if.valid && scan_if.ready) || (evt_if.valid && evt_if.ready))
                quiet_cnt <= 0;
            else if (quiet_cnt < SETTLE_CYC)
                quiet_cnt <= quiet_cnt + 1;
        end
        evt_if.ready <= nxt_ready;
        nothing_due  <= pending_events.size() == 0;
        wd_cnt       <= any_xfer ? 0 : wd_cnt + 1;
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any transaction ends the run
    // ------------------------------------------------------------------------
    initial begin : watchdog
        while (wd_cnt < WD_LIMIT) @(posedge i_clk);
        $display("[%0t] watchdog: no transaction for %0d cycles", $time, WD_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence: stimulus plan, reset, end of run
    // ------------------------------------------------------------------------
    initial begin : main_seq
        // known values on every input before the first edge
        i_rst_n          = 1'b0;
        scan_if.valid    = 1'b0;
        scan_if.scancode = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = CFG_START_COLUMN;
        cfg_if.data      = '0;
        evt_if.ready     = 1'b0;

        load_keymap();

        // directed part on reset settings: column 1, row 3
        queue_code(CODE_BKSP);                  // erase at column 0
        queue_code(CODE_BKSP);                  // left edge, dropped
        queue_code(SC_KEY_A);                   // plain letter
        queue_code(CODE_LSHIFT);
        queue_code(SC_KEY_A);                   // upper case, shift consumed
        queue_code(CODE_LSHIFT);
        queue_code(SHIFT_BREAK);
        queue_code(8'h1f);                      // shift released, lower case
        queue_code(CODE_LSHIFT);
        queue_code(SC_SPACE);                   // shifted space wraps to 0x00
        queue_code(CODE_LSHIFT);
        queue_code(SC_TAB);                     // shifted tab wraps to 0xe9
        queue_code(CODE_LSHIFT);
        queue_code(SC_UNMAPPED);                // unmapped make keeps shift
        queue_code(8'h10);
        queue_code(SC_KEY_A_UP);                // other breaks do nothing
        queue_code(8'h00);
        queue_code(8'h7f);
        queue_code(RELEASE_MASK);
        queue_code(8'hff);
        queue_code(8'h3a);
        queue_code(CODE_LSHIFT);
        queue_code(SC_KEY_A_UP);                // non-shift release, shift held
        queue_code(8'h02);
        queue_code(8'h0b);
        queue_code(8'h0d);
        queue_code(8'h32);
        queue_code(CODE_BKSP);

        // random phases across register settings, extremes first
        queue_settings(0, 0);
        queue_phase(200, 55, -1);
        // mostly typing from the widest start so the column wraps past 255
        queue_settings(79, 24);
        queue_phase(220, 92, -1);
        queue_settings($urandom_range(0, 79), $urandom_range(0, 24));
        queue_phase(200, 55, 100);              // sender drains mid-phase
        queue_settings($urandom_range(0, 79), $urandom_range(0, 24));
        queue_phase(200, 65, -1);
        queue_settings($urandom_range(0, 79), $urandom_range(0, 24));
        queue_phase(250, 55, -1);
        queue_settle();

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // everything sent and drained, then a last wait for strays
        wait (stim_done);
        repeat (END_CYC) @(posedge i_clk);
        if (pending_events.size() != 0)
            note_mismatch("events never delivered", 0, pending_events.size());

        $display("summary: %0d scancodes, %0d prints (%0d shifted), %0d erases",
                 scan_cnt, print_cnt, shifted_cnt, erase_cnt);
        $display("summary: %0d register writes, cursor column wrapped %0d times",
                 cfg_cnt, wrap_cnt);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
